// ===== sv/ugcb_pkg.sv =====
// ----------------------------------------------------------------------------
// ugcb_pkg
// Shared types and codes for the uniform grid cell binning block.
// ----------------------------------------------------------------------------
package ugcb_pkg;

    localparam int COORD_W   = 24;
    localparam int EDGE_W    = 23;
    localparam int KIND_W    = 2;
    localparam int QIDX_W    = 12;
    localparam int STATUS_W  = 2;
    localparam int PID_W     = 10;
    localparam int CIDX_W    = 12;
    localparam int RANGE_W   = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUILD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QCELL  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QSLOT  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_GRID  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // bound registers take indexes below this one
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [QIDX_W-1:0]         query_index;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PID_W-1:0]    particle_id;
        logic [CIDX_W-1:0]   cell_index;
        logic [RANGE_W-1:0]  range_start;
        logic [RANGE_W-1:0]  range_end;
        logic [RANGE_W-1:0]  total;
    } out_item_t;

endpackage

// ===== sv/ugcb_div.sv =====
// ----------------------------------------------------------------------------
// ugcb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ugcb_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 23
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    assign rem_shift = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign done      = done_reg;
    assign quo       = quo_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? rem_sub : rem_shift;
        end
    end

endmodule

// ===== sv/uniform_grid_cell_binning.sv =====
// ----------------------------------------------------------------------------
// uniform_grid_cell_binning
// Bins 3D Q15.8 positions into a uniform grid and counting-sorts them by cell.
// ----------------------------------------------------------------------------
// Append: up to 3 divisions in the shared bit-serial divider, one per axis.
// Build: prefix sums over the grid cells, then a scatter of the particles; a
// repeated build only reports the total. Queries read the memories, an error
// answer skips it. One item at a time; a result waits in an output register.
// After reset and after every config write to a bound or the edge the count
// memory is cleared, then the grid is sized by up to 3 divisions; no item is
// taken meanwhile, config writes are.
module uniform_grid_cell_binning
    import ugcb_pkg::*;
#(
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_CELLS     = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    localparam int PW = $clog2(MAX_PARTICLES);
    localparam int LW = $clog2(MAX_PARTICLES + 1);
    localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int NW = $clog2(MAX_CELLS + 1);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_DDIV  = 5'd1;
    localparam logic [4:0] S_DWAIT = 5'd2;
    localparam logic [4:0] S_DM1   = 5'd3;
    localparam logic [4:0] S_DM2   = 5'd4;
    localparam logic [4:0] S_DM3   = 5'd5;
    localparam logic [4:0] S_IDLE  = 5'd6;
    localparam logic [4:0] S_ADIV  = 5'd7;
    localparam logic [4:0] S_AWAIT = 5'd8;
    localparam logic [4:0] S_AM1   = 5'd9;
    localparam logic [4:0] S_AM2   = 5'd10;
    localparam logic [4:0] S_ARD   = 5'd11;
    localparam logic [4:0] S_AWR   = 5'd12;
    localparam logic [4:0] S_PRD   = 5'd13;
    localparam logic [4:0] S_PWR   = 5'd14;
    localparam logic [4:0] S_SRD1  = 5'd15;
    localparam logic [4:0] S_SRD2  = 5'd16;
    localparam logic [4:0] S_SWR   = 5'd17;
    localparam logic [4:0] S_QRD   = 5'd18;
    localparam logic [4:0] S_QOUT  = 5'd19;
    localparam logic [4:0] S_FIN   = 5'd20;

    logic [4:0]                state_reg;
    logic signed [COORD_W-1:0] bound_reg [6];
    logic [EDGE_W-1:0]         cell_edge_reg;
    logic [1:0]                ax_reg;
    logic [NW-1:0]             n_reg [3];
    logic [CW-1:0]             c_reg [3];
    logic [2*NW-1:0]           prod_reg;
    logic [NW-1:0]             cells_reg;
    logic                      grid_ok_reg;
    logic                      built_reg;
    logic [LW-1:0]             loaded_reg;
    logic [CW-1:0]             clr_reg;
    logic [CW-1:0]             k_reg;
    logic [LW-1:0]             off_reg;
    logic [PW-1:0]             i_reg;
    logic [CW-1:0]             t_reg;
    logic [CW-1:0]             idx_reg;
    in_item_t                  item_reg;
    out_item_t                 res_reg;
    logic                      out_valid_reg;
    out_item_t                 out_data_reg;

    logic [LW-1:0] count_mem  [MAX_CELLS];
    logic [LW-1:0] begin_mem  [MAX_CELLS];
    logic [LW-1:0] finish_mem [MAX_CELLS];
    logic [LW-1:0] cursor_mem [MAX_CELLS];
    logic [CW-1:0] pcell_mem  [MAX_PARTICLES];
    logic [PW-1:0] sorted_mem [MAX_PARTICLES];

    logic          count_we;
    logic [CW-1:0] count_waddr;
    logic [LW-1:0] count_wdata;
    logic [CW-1:0] count_raddr;
    logic [LW-1:0] count_rd;
    logic          pre_we;
    logic [LW-1:0] begin_rd;
    logic [LW-1:0] finish_rd;
    logic          cursor_we;
    logic [CW-1:0] cursor_waddr;
    logic [LW-1:0] cursor_wdata;
    logic [LW-1:0] cursor_rd;
    logic          pcell_we;
    logic [CW-1:0] pcell_rd;
    logic          sorted_we;
    logic [PW-1:0] sorted_rd;
    logic [CW-1:0] qcell_addr;
    logic [PW-1:0] qslot_addr;

    logic signed [COORD_W-1:0] lo_sel;
    logic signed [COORD_W-1:0] hi_sel;
    logic signed [COORD_W-1:0] pos_sel;
    logic signed [COORD_W-1:0] minuend;
    logic signed [COORD_W:0]   diff;
    logic                      diff_neg;
    logic                      div_start;
    logic                      div_done;
    logic [COORD_W-1:0]        div_quo;
    logic                      cfg_wr;

    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && (cfg_index <= CFG_EDGE);
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign qcell_addr = CW'(item_reg.query_index);
    assign qslot_addr = PW'(item_reg.query_index);

    always_comb begin
        lo_sel = bound_reg[{ax_reg, 1'b0}];
        hi_sel = bound_reg[{ax_reg, 1'b1}];
        unique case (ax_reg)
            2'd0:    pos_sel = item_reg.pos_x;
            2'd1:    pos_sel = item_reg.pos_y;
            default: pos_sel = item_reg.pos_z;
        endcase
        minuend   = (state_reg == S_ADIV) ? pos_sel : hi_sel;
        diff      = {minuend[COORD_W-1], minuend} - {lo_sel[COORD_W-1], lo_sel};
        diff_neg  = diff[COORD_W];
        div_start = !diff_neg && (((state_reg == S_DDIV) && (cell_edge_reg != '0))
                    || (state_reg == S_ADIV));
    end

    ugcb_div #(
        .NUM_W(COORD_W),
        .DEN_W(EDGE_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (diff[COORD_W-1:0]),
        .den  (cell_edge_reg),
        .done (div_done),
        .quo  (div_quo)
    );

    always_comb begin
        count_we     = 1'b0;
        count_waddr  = clr_reg;
        count_wdata  = '0;
        count_raddr  = k_reg;
        pre_we       = 1'b0;
        cursor_we    = 1'b0;
        cursor_waddr = k_reg;
        cursor_wdata = off_reg;
        pcell_we     = 1'b0;
        sorted_we    = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                count_we = 1'b1;
            end
            S_ARD:
            begin
                count_raddr = idx_reg;
            end
            S_AWR:
            begin
                count_raddr = idx_reg;
                count_we    = 1'b1;
                count_waddr = idx_reg;
                count_wdata = count_rd + 1'b1;
                pcell_we    = 1'b1;
            end
            S_PWR:
            begin
                count_we    = 1'b1;
                count_waddr = k_reg;
                pre_we      = 1'b1;
                cursor_we   = 1'b1;
            end
            S_SWR:
            begin
                cursor_we    = 1'b1;
                cursor_waddr = pcell_rd;
                cursor_wdata = cursor_rd + 1'b1;
                sorted_we    = 1'b1;
            end
            default:
            begin
                count_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (count_we)
            count_mem[count_waddr] <= count_wdata;
        count_rd <= count_mem[count_raddr];
    end

    always_ff @(posedge clk) begin
        if (pre_we)
        begin
            begin_mem[k_reg]  <= off_reg;
            finish_mem[k_reg] <= off_reg + count_rd;
        end
        begin_rd  <= begin_mem[qcell_addr];
        finish_rd <= finish_mem[qcell_addr];
    end

    always_ff @(posedge clk) begin
        if (cursor_we)
            cursor_mem[cursor_waddr] <= cursor_wdata;
        cursor_rd <= cursor_mem[pcell_rd];
    end

    always_ff @(posedge clk) begin
        if (pcell_we)
            pcell_mem[PW'(loaded_reg)] <= idx_reg;
        pcell_rd <= pcell_mem[i_reg];
    end

    always_ff @(posedge clk) begin
        if (sorted_we)
            sorted_mem[PW'(cursor_rd)] <= i_reg;
        sorted_rd <= sorted_mem[qslot_addr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            bound_reg[0]  <= 24'sd0;
            bound_reg[1]  <= 24'sd4096;
            bound_reg[2]  <= 24'sd0;
            bound_reg[3]  <= 24'sd4096;
            bound_reg[4]  <= 24'sd0;
            bound_reg[5]  <= 24'sd4096;
            cell_edge_reg <= EDGE_W'(256);
            ax_reg        <= '0;
            clr_reg       <= '0;
            grid_ok_reg   <= 1'b0;
            built_reg     <= 1'b0;
            loaded_reg    <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !((state_reg == S_FIN) && !cfg_wr))
                out_valid_reg <= 1'b0;
            if (cfg_wr)
            begin
                if (cfg_index == CFG_EDGE)
                    cell_edge_reg <= cfg_data[EDGE_W-1:0];
                else
                    bound_reg[cfg_index] <= cfg_data;
                state_reg   <= S_CLR;
                clr_reg     <= '0;
                ax_reg      <= '0;
                grid_ok_reg <= 1'b0;
                built_reg   <= 1'b0;
                loaded_reg  <= '0;
                res_reg     <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_CLR:
                    begin
                        clr_reg <= clr_reg + 1'b1;
                        if (32'(clr_reg) == MAX_CELLS - 1)
                        begin
                            ax_reg    <= '0;
                            state_reg <= S_DDIV;
                        end
                    end
                    S_DDIV:
                    begin
                        if (cell_edge_reg == '0)
                            state_reg <= S_IDLE;
                        else if (diff_neg)
                        begin
                            n_reg[ax_reg] <= NW'(1);
                            if (ax_reg == 2'd2)
                                state_reg <= S_DM1;
                            else
                                ax_reg <= ax_reg + 1'b1;
                        end
                        else
                            state_reg <= S_DWAIT;
                    end
                    S_DWAIT:
                    begin
                        if (div_done)
                        begin
                            if (32'(div_quo) >= MAX_CELLS)
                                state_reg <= S_IDLE;
                            else
                            begin
                                n_reg[ax_reg] <= NW'(32'(div_quo) + 1);
                                if (ax_reg == 2'd2)
                                    state_reg <= S_DM1;
                                else
                                begin
                                    ax_reg    <= ax_reg + 1'b1;
                                    state_reg <= S_DDIV;
                                end
                            end
                        end
                    end
                    S_DM1:
                    begin
                        prod_reg  <= n_reg[0] * n_reg[1];
                        state_reg <= S_DM2;
                    end
                    S_DM2:
                    begin
                        if (64'(prod_reg) > 64'(MAX_CELLS))
                            state_reg <= S_IDLE;
                        else
                        begin
                            prod_reg  <= prod_reg[NW-1:0] * n_reg[2];
                            state_reg <= S_DM3;
                        end
                    end
                    S_DM3:
                    begin
                        if (64'(prod_reg) <= 64'(MAX_CELLS))
                        begin
                            cells_reg   <= prod_reg[NW-1:0];
                            grid_ok_reg <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                    S_IDLE:
                    begin
                        if (in_valid)
                        begin
                            item_reg <= in_data;
                            ax_reg   <= '0;
                            unique case (in_data.kind)
                                KIND_APPEND:
                                begin
                                    if (!grid_ok_reg)
                                    begin
                                        res_reg.status <= ST_GRID;
                                        state_reg      <= S_FIN;
                                    end
                                    else if (built_reg)
                                    begin
                                        built_reg  <= 1'b0;
                                        loaded_reg <= '0;
                                        state_reg  <= S_ADIV;
                                    end
                                    else if (32'(loaded_reg) == MAX_PARTICLES)
                                    begin
                                        res_reg.status <= ST_FULL;
                                        state_reg      <= S_FIN;
                                    end
                                    else
                                        state_reg <= S_ADIV;
                                end
                                KIND_BUILD:
                                begin
                                    if (!grid_ok_reg)
                                    begin
                                        res_reg.status <= ST_GRID;
                                        state_reg      <= S_FIN;
                                    end
                                    else if (built_reg)
                                    begin
                                        res_reg.total <= RANGE_W'(loaded_reg);
                                        state_reg     <= S_FIN;
                                    end
                                    else
                                    begin
                                        k_reg     <= '0;
                                        off_reg   <= '0;
                                        state_reg <= S_PRD;
                                    end
                                end
                                KIND_QCELL:
                                begin
                                    if (!grid_ok_reg)
                                    begin
                                        res_reg.status <= ST_GRID;
                                        state_reg      <= S_FIN;
                                    end
                                    else if (32'(in_data.query_index) >= 32'(cells_reg))
                                    begin
                                        res_reg.status <= ST_RANGE;
                                        state_reg      <= S_FIN;
                                    end
                                    else if (!built_reg)
                                        state_reg <= S_FIN;
                                    else
                                        state_reg <= S_QRD;
                                end
                                KIND_QSLOT:
                                begin
                                    if (!built_reg ||
                                        32'(in_data.query_index) >= 32'(loaded_reg))
                                    begin
                                        res_reg.status <= ST_RANGE;
                                        state_reg      <= S_FIN;
                                    end
                                    else
                                        state_reg <= S_QRD;
                                end
                            endcase
                        end
                    end
                    S_ADIV:
                    begin
                        if (diff_neg)
                        begin
                            c_reg[ax_reg] <= '0;
                            if (ax_reg == 2'd2)
                                state_reg <= S_AM1;
                            else
                                ax_reg <= ax_reg + 1'b1;
                        end
                        else
                            state_reg <= S_AWAIT;
                    end
                    S_AWAIT:
                    begin
                        if (div_done)
                        begin
                            if (32'(div_quo) > 32'(n_reg[ax_reg]) - 1)
                                c_reg[ax_reg] <= CW'(32'(n_reg[ax_reg]) - 1);
                            else
                                c_reg[ax_reg] <= CW'(div_quo);
                            if (ax_reg == 2'd2)
                                state_reg <= S_AM1;
                            else
                            begin
                                ax_reg    <= ax_reg + 1'b1;
                                state_reg <= S_ADIV;
                            end
                        end
                    end
                    S_AM1:
                    begin
                        t_reg     <= CW'(c_reg[2] * n_reg[1] + c_reg[1]);
                        state_reg <= S_AM2;
                    end
                    S_AM2:
                    begin
                        idx_reg   <= CW'(t_reg * n_reg[0] + c_reg[0]);
                        state_reg <= S_ARD;
                    end
                    S_ARD:
                    begin
                        state_reg <= S_AWR;
                    end
                    S_AWR:
                    begin
                        loaded_reg             <= loaded_reg + 1'b1;
                        res_reg.particle_id    <= PID_W'(loaded_reg);
                        res_reg.cell_index     <= CIDX_W'(idx_reg);
                        state_reg              <= S_FIN;
                    end
                    S_PRD:
                    begin
                        state_reg <= S_PWR;
                    end
                    S_PWR:
                    begin
                        off_reg <= off_reg + count_rd;
                        if (32'(k_reg) + 1 == 32'(cells_reg))
                        begin
                            i_reg <= '0;
                            if (loaded_reg == '0)
                            begin
                                built_reg     <= 1'b1;
                                res_reg.total <= RANGE_W'(loaded_reg);
                                state_reg     <= S_FIN;
                            end
                            else
                                state_reg <= S_SRD1;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_PRD;
                        end
                    end
                    S_SRD1:
                    begin
                        state_reg <= S_SRD2;
                    end
                    S_SRD2:
                    begin
                        state_reg <= S_SWR;
                    end
                    S_SWR:
                    begin
                        if (32'(i_reg) + 1 == 32'(loaded_reg))
                        begin
                            built_reg     <= 1'b1;
                            res_reg.total <= RANGE_W'(loaded_reg);
                            state_reg     <= S_FIN;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_SRD1;
                        end
                    end
                    S_QRD:
                    begin
                        state_reg <= S_QOUT;
                    end
                    S_QOUT:
                    begin
                        if (item_reg.kind == KIND_QCELL)
                        begin
                            res_reg.range_start <= RANGE_W'(begin_rd);
                            res_reg.range_end   <= RANGE_W'(finish_rd);
                        end
                        else
                            res_reg.particle_id <= PID_W'(sorted_rd);
                        state_reg <= S_FIN;
                    end
                    S_FIN:
                    begin
                        if (!out_valid_reg || out_ready)
                        begin
                            out_valid_reg <= 1'b1;
                            out_data_reg  <= res_reg;
                            res_reg       <= '0;
                            state_reg     <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(loaded_reg) <= MAX_PARTICLES)
        else $error("particle count above store depth");

    a_built_grid: assert property (@(posedge clk) disable iff (!rst_n)
        built_reg |-> grid_ok_reg)
        else $error("sorted set on an invalid grid");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg != S_IDLE)
        else $error("item accepted without leaving idle");

    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && (!out_valid_reg || out_ready) && !cfg_wr
        |=> out_valid_reg)
        else $error("finished item not presented");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid binning testbench
// Drives appends, builds and range/slot queries through the grid binning block
// under several grid settings and idle patterns, predicts every result with a
// behavioral copy of the binning and counting sort, and checks each field.
// ----------------------------------------------------------------------------
module testbench;
    import ugcb_pkg::*;

    localparam int NUM_PART  = 1024;
    localparam int NUM_CELLS = 4096;
    localparam int LIMIT     = 4000000;
    localparam int IN_W      = $bits(in_item_t);

    localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    class grid_scoreboard;
        longint      bound[6];
        longint      cell_len;
        longint      dims[3];
        int unsigned part_cell[NUM_PART];
        int unsigned cnt[NUM_CELLS];
        int unsigned beg[NUM_CELLS];
        int unsigned fin[NUM_CELLS];
        int unsigned cursor[NUM_CELLS];
        int unsigned sorted[NUM_PART];
        int unsigned loaded;
        bit          built;
        out_item_t   expected_q[$];
        int          errors;
        int          checked;

        function new();
            for (int a = 0; a < 3; a++)
            begin
                bound[2*a]   = 0;
                bound[2*a+1] = 4096;
            end
            cell_len = 256;
            errors   = 0;
            checked  = 0;
            clear_set();
        endfunction

        function void clear_set();
            for (int c = 0; c < NUM_CELLS; c++)
            begin
                cnt[c] = 0;
                beg[c] = 0;
                fin[c] = 0;
            end
            loaded = 0;
            built  = 0;
        endfunction

        function longint floor_div(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0)
                q = q - 1;
            return q;
        endfunction

        // total cells, 0 when the grid is invalid or too large
        function longint grid_cells();
            longint prod;
            prod = 1;
            if (cell_len == 0)
                return 0;
            for (int a = 0; a < 3; a++)
            begin
                dims[a] = floor_div(bound[2*a+1] - bound[2*a], cell_len) + 1;
                if (dims[a] < 1)
                    dims[a] = 1;
                if (dims[a] > NUM_CELLS)
                    return 0;
                prod = prod * dims[a];
                if (prod > NUM_CELLS)
                    return 0;
            end
            return prod;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
            if (idx < CFG_EDGE)
                bound[idx] = longint'($signed(val));
            else if (idx == CFG_EDGE)
                cell_len = longint'(val[EDGE_W-1:0]);
            else
                return;
            clear_set();
        endfunction

        function void note_item(in_item_t it);
            out_item_t e;
            longint    cells;
            longint    c[3];
            longint    p;
            int unsigned cell_id, off, dst;
            e = '0;
            cells = grid_cells();
            case (it.kind)
                KIND_APPEND:
                begin
                    if (cells == 0)
                        e.status = ST_GRID;
                    else
                    begin
                        if (built)
                            clear_set();
                        if (loaded >= NUM_PART)
                            e.status = ST_FULL;
                        else
                        begin
                            for (int a = 0; a < 3; a++)
                            begin
                                p = (a == 0) ? longint'(it.pos_x) :
                                    (a == 1) ? longint'(it.pos_y) : longint'(it.pos_z);
                                c[a] = floor_div(p - bound[2*a], cell_len);
                                if (c[a] < 0)
                                    c[a] = 0;
                                if (c[a] > dims[a] - 1)
                                    c[a] = dims[a] - 1;
                            end
                            cell_id = int'(c[2]*dims[1]*dims[0] + c[1]*dims[0] + c[0]);
                            part_cell[loaded] = cell_id;
                            cnt[cell_id]++;
                            e.particle_id = loaded[PID_W-1:0];
                            e.cell_index  = cell_id[CIDX_W-1:0];
                            loaded++;
                        end
                    end
                end
                KIND_BUILD:
                begin
                    if (cells == 0)
                        e.status = ST_GRID;
                    else
                    begin
                        off = 0;
                        for (int k = 0; k < cells; k++)
                        begin
                            beg[k]    = off;
                            cursor[k] = off;
                            off       = off + cnt[k];
                            fin[k]    = off;
                        end
                        for (int i = 0; i < loaded; i++)
                        begin
                            dst = cursor[part_cell[i]];
                            cursor[part_cell[i]] = dst + 1;
                            if (dst < NUM_PART)
                                sorted[dst] = i;
                        end
                        built   = 1;
                        e.total = loaded[RANGE_W-1:0];
                    end
                end
                KIND_QCELL:
                begin
                    if (cells == 0)
                        e.status = ST_GRID;
                    else if (it.query_index >= cells)
                        e.status = ST_RANGE;
                    else
                    begin
                        e.range_start = beg[it.query_index][RANGE_W-1:0];
                        e.range_end   = fin[it.query_index][RANGE_W-1:0];
                    end
                end
                default:
                begin
                    if (!built || it.query_index >= loaded)
                        e.status = ST_RANGE;
                    else
                        e.particle_id = sorted[it.query_index][PID_W-1:0];
                end
            endcase
            expected_q.push_back(e);
        endfunction

        task report(string field, longint got, longint want);
            $display("[%0t] %s: got %0d, expected %0d", $realtime, field, got, want);
            errors++;
        endtask

        task check_result(out_item_t got);
            out_item_t e;
            if (expected_q.size() == 0)
            begin
                report("unexpected result, status", got.status, -1);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.status != e.status)
                report("status", got.status, e.status);
            if (got.particle_id != e.particle_id)
                report("particle_id", got.particle_id, e.particle_id);
            if (got.cell_index != e.cell_index)
                report("cell_index", got.cell_index, e.cell_index);
            if (got.range_start != e.range_start)
                report("range_start", got.range_start, e.range_start);
            if (got.range_end != e.range_end)
                report("range_end", got.range_end, e.range_end);
            if (got.total != e.total)
                report("total", got.total, e.total);
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]   cfg_data = '0;

    grid_scoreboard sb = new();
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int cycles    = 0;
    int sent      = 0;
    int reg_writes = 0;

    uniform_grid_cell_binning dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: check, then decide next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_item(it);
        sent++;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
        reg_writes++;
    endtask

    task automatic set_grid(input longint lo[3], input longint hi[3], input longint len);
        wait_drain();
        for (int a = 0; a < 3; a++)
        begin
            write_reg(REG_LEFT + CFG_IDX_W'(2*a), lo[a][COORD_W-1:0]);
            write_reg(REG_LEFT + CFG_IDX_W'(2*a + 1), hi[a][COORD_W-1:0]);
        end
        write_reg(CFG_EDGE, len[COORD_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_grid();
        longint lo[3], hi[3], len;
        len = $urandom_range(1, 65536);
        for (int a = 0; a < 3; a++)
        begin
            lo[a] = longint'($urandom_range(0, 16777215 - 600000)) - 8388608;
            if ($urandom_range(5) == 0)
                hi[a] = lo[a] - $urandom_range(1, 1000);
            else
                hi[a] = lo[a] + ($urandom_range(1, 8) - 1) * len + $urandom_range(0, len - 1);
        end
        set_grid(lo, hi, len);
    endtask

    function automatic logic [COORD_W-1:0] pick_pos(int a);
        longint v, span;
        if ($urandom_range(7) == 0)
            return COORD_W'($urandom);
        span = sb.bound[2*a+1] - sb.bound[2*a];
        if (span < 0)
            span = 0;
        v = sb.bound[2*a] + longint'($urandom_range(0, int'(span + sb.cell_len)));
        if (v > 8388607)
            v = 8388607;
        return v[COORD_W-1:0];
    endfunction

    function automatic in_item_t make_item(logic [KIND_W-1:0] k);
        in_item_t it;
        longint cells;
        it       = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
        it.kind  = k;
        cells    = sb.grid_cells();
        if (k == KIND_APPEND)
        begin
            it.pos_x = pick_pos(0);
            it.pos_y = pick_pos(1);
            it.pos_z = pick_pos(2);
        end
        else if (k == KIND_QCELL && cells > 0 && $urandom_range(7) != 0)
            it.query_index = QIDX_W'($urandom_range(0, int'(cells - 1)));
        else if (k == KIND_QSLOT && $urandom_range(7) != 0)
            it.query_index = QIDX_W'($urandom_range(0, sb.loaded));
        return it;
    endfunction

    // append a set, build, then query it; some noise mixed in
    task automatic run_set();
        int n;
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++)
            send_item(make_item(KIND_APPEND));
        if ($urandom_range(9) == 0)
            send_item(in_item_t'(IN_W'({$urandom, $urandom, $urandom})));
        send_item(make_item(KIND_BUILD));
        n = $urandom_range(2, 12);
        for (int i = 0; i < n; i++)
            send_item(make_item($urandom_range(1) ? KIND_QCELL : KIND_QSLOT));
    endtask

    task automatic directed();
        in_item_t it;
        longint lo[3], hi[3];
        // reset grid is 17^3 cells: too large
        send_item(make_item(KIND_APPEND));
        send_item(make_item(KIND_BUILD));
        send_item(make_item(KIND_QCELL));
        send_item(make_item(KIND_QSLOT));
        // widest bounds, largest edge: 3 cells per axis
        lo = '{-8388608, -8388608, -8388608};
        hi = '{8388607, 8388607, 8388607};
        set_grid(lo, hi, 8388607);
        it = '0;
        it.kind  = KIND_APPEND;
        it.pos_x = 24'sh7FFFFF; it.pos_y = 24'sh800000; it.pos_z = 24'sh7FFFFF;
        send_item(it);
        it.pos_x = 24'sh800000; it.pos_y = 24'sh7FFFFF; it.pos_z = 24'sh000000;
        send_item(it);
        it.pos_x = 24'sh000000; it.pos_y = 24'sh000000; it.pos_z = 24'sh800000;
        send_item(it);
        it.kind = KIND_QSLOT; it.query_index = 12'd0;
        send_item(it);                         // not built yet
        it.kind = KIND_QCELL; it.query_index = 12'd26;
        send_item(it);                         // ranges still zero
        it.kind = KIND_BUILD;
        send_item(it);
        send_item(it);                         // repeated build
        for (int q = 0; q < 3; q++)
        begin
            it.kind = KIND_QSLOT; it.query_index = QIDX_W'(q);
            send_item(it);
        end
        it.query_index = 12'hFFF;
        send_item(it);
        it.kind = KIND_QCELL; it.query_index = 12'd27;
        send_item(it);                         // just past last cell
        it.query_index = 12'hFFF;
        send_item(it);
        send_item(make_item(KIND_APPEND));     // new set after build
        it.kind = KIND_QSLOT; it.query_index = 12'd0;
        send_item(it);
        // zero edge: invalid grid
        wait_drain();
        write_reg(CFG_EDGE, '0);
        write_reg(REG_SPARE, 24'hFFFFFF);
        cfg_valid <= 1'b0;
        send_item(make_item(KIND_APPEND));
        send_item(make_item(KIND_QCELL));
        // edge of one, single cell
        lo = '{0, 0, 0};
        hi = '{0, 0, 0};
        set_grid(lo, hi, 1);
        send_item(make_item(KIND_APPEND));
        send_item(make_item(KIND_BUILD));
        // exactly MAX_CELLS cells
        hi = '{3840, 3840, 3840};
        set_grid(lo, hi, 256);
        send_item(make_item(KIND_APPEND));
        send_item(make_item(KIND_BUILD));
    endtask

    initial
    begin
        int idle_set[4]  = '{0, 78, 0, 15};
        int stall_set[4] = '{0, 0, 78, 15};
        longint lo[3], hi[3];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = idle_set[ph];
            stall_pct = stall_set[ph];
            random_grid();
            for (int s = 0; s < 6; s++)
            begin
                if (s == 3)
                    random_grid();
                run_set();
            end
            if (ph == 0)
            begin
                // long receiver hold-off while items keep coming
                hold_left = 1500;
                for (int i = 0; i < 30; i++)
                    send_item(make_item($urandom_range(3)));
                wait_drain();
                run_set();
            end
        end
        // fill the particle store
        idle_pct  = 0;
        stall_pct = 0;
        lo = '{-512, -512, -512};
        hi = '{511, 511, 511};
        set_grid(lo, hi, 512);
        for (int i = 0; i < NUM_PART + 6; i++)
            send_item(make_item(KIND_APPEND));
        send_item(make_item(KIND_BUILD));
        for (int i = 0; i < 12; i++)
            send_item(make_item(KIND_QSLOT));
        for (int i = 0; i < 8; i++)
            send_item(make_item(KIND_QCELL));
        send_item(make_item(KIND_APPEND));
        wait_drain();
        repeat (100) @(posedge clk);
        $display("Covered %0d items and %0d register writes; %0d results checked.",
                 sent, reg_writes, sb.checked);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
